>>> src/psl_pkg.sv
// Shared types and constants for the periodic sample logger.
package psl_pkg;

  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_SAMPLE = 3'd1;
  localparam logic [2:0] CMD_READ   = 3'd2;
  localparam logic [2:0] CMD_FLUSH  = 3'd3;
  localparam logic [2:0] CMD_WAKE   = 3'd4;

  localparam logic [2:0] REG_MEASURE_INTERVAL   = 3'd0;
  localparam logic [2:0] REG_COMMS_INTERVAL     = 3'd1;
  localparam logic [2:0] REG_AWAKE_SECONDS      = 3'd2;
  localparam logic [2:0] REG_SENSOR_COUNT       = 3'd3;
  localparam logic [2:0] REG_RECORDS_PER_SENSOR = 3'd4;

  localparam logic [15:0] RST_MEASURE_INTERVAL   = 16'd120;
  localparam logic [15:0] RST_COMMS_INTERVAL     = 16'd3600;
  localparam logic [7:0]  RST_AWAKE_SECONDS      = 8'd30;
  localparam logic [3:0]  RST_SENSOR_COUNT       = 4'd1;
  localparam logic [10:0] RST_RECORDS_PER_SENSOR = 11'd1024;

  // stored in place of a failed reading
  localparam logic [15:0] BROKEN_MARK = 16'h07D1;

  // wide enough for sensor * records + record and for a depth of 65536
  localparam int ADDR_CALC_W = 17;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [2:0]  sensor_index;
    logic [9:0]  record_index;
    logic [15:0] sample_value;
    logic        sample_ok;
    logic        last_sensor;
  } item_t;

  typedef struct packed {
    logic        measure_due;
    logic        comms_due;
    logic        awake;
    logic [15:0] read_data;
    logic        read_valid;
    logic [10:0] record_count;
    logic [31:0] epoch_now;
    logic [31:0] first_epoch;
    logic [31:0] last_epoch;
    logic        write_dropped;
  } result_t;

  typedef struct packed {
    logic [15:0] measure_interval;
    logic [15:0] comms_interval;
    logic [7:0]  awake_seconds;
    logic [3:0]  sensor_count;
    logic [10:0] records_per_sensor;
  } cfg_t;

  // timer state as it stands after the current beat
  typedef struct packed {
    logic        measure_due;
    logic        comms_due;
    logic        awake;
    logic [31:0] epoch;
  } timer_status_t;

  // log state as it stands after the current beat
  typedef struct packed {
    logic        read_valid;
    logic [10:0] record_count;
    logic [31:0] first_epoch;
    logic [31:0] last_epoch;
    logic        write_dropped;
  } log_status_t;

endpackage

>>> src/psl_ram.sv
// Generic single-port synchronous RAM with registered read.
module psl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

>>> src/psl_timers.sv
// Epoch clock, measure/comms interval counters and awake countdown.
module psl_timers #(
  parameter int TICK_SECONDS = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic [2:0]            cmd,
  input  psl_pkg::cfg_t         cfg,
  output psl_pkg::timer_status_t status
);

  localparam logic [15:0] TICK16 = 16'(TICK_SECONDS);
  localparam logic [31:0] TICK32 = 32'(TICK_SECONDS);
  localparam logic [7:0]  TICK8  = 8'(TICK_SECONDS);

  logic [31:0] epoch, epoch_next;
  logic [15:0] measure_counter, measure_counter_next;
  logic [15:0] comms_counter, comms_counter_next;
  logic [7:0]  awake_countdown, awake_countdown_next;
  logic [15:0] measure_sum, comms_sum;
  logic        measure_hit, comms_hit;

  always_comb begin
    measure_sum = measure_counter + TICK16;
    comms_sum   = comms_counter + TICK16;
    measure_hit = measure_sum >= cfg.measure_interval;
    comms_hit   = comms_sum >= cfg.comms_interval;

    epoch_next           = epoch;
    measure_counter_next = measure_counter;
    comms_counter_next   = comms_counter;
    awake_countdown_next = awake_countdown;
    status.measure_due   = 1'b0;
    status.comms_due     = 1'b0;

    if (cmd == psl_pkg::CMD_TICK) begin
      epoch_next           = epoch + TICK32;
      measure_counter_next = measure_hit ? 16'd0 : measure_sum;
      comms_counter_next   = comms_hit ? 16'd0 : comms_sum;
      // saturate at zero
      awake_countdown_next = (awake_countdown >= TICK8) ? awake_countdown - TICK8 : 8'd0;
      status.measure_due   = measure_hit;
      status.comms_due     = comms_hit;
    end else if (cmd == psl_pkg::CMD_WAKE) begin
      awake_countdown_next = cfg.awake_seconds;
    end

    status.awake = awake_countdown_next != 8'd0;
    status.epoch = epoch_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch           <= '0;
      measure_counter <= '0;
      comms_counter   <= '0;
      awake_countdown <= '0;
    end else if (fire) begin
      epoch           <= epoch_next;
      measure_counter <= measure_counter_next;
      comms_counter   <= comms_counter_next;
      awake_countdown <= awake_countdown_next;
    end
  end

endmodule

>>> src/psl_log.sv
// Record counter, time stamps and the sample store access.
module psl_log #(
  parameter int STORE_DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  psl_pkg::item_t       item,
  input  psl_pkg::cfg_t        cfg,
  input  logic [31:0]          epoch,
  output psl_pkg::log_status_t status,
  output logic [15:0]          store_q
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = psl_pkg::ADDR_CALC_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

  logic [10:0]   record_counter, record_counter_next;
  logic [31:0]   first_stamp, first_stamp_next;
  logic [31:0]   last_stamp, last_stamp_next;
  logic [10:0]   rec_eff;
  logic [CW-1:0] base, wr_addr, rd_addr;
  logic          wr_in_range, rd_in_range;
  logic          is_sample, is_read;
  logic          ram_en, ram_we;
  logic [AW-1:0] ram_addr;
  logic [15:0]   ram_wdata;

  always_comb begin
    is_sample = item.cmd == psl_pkg::CMD_SAMPLE;
    is_read   = item.cmd == psl_pkg::CMD_READ;

    // full store: record count restarts before the write
    rec_eff     = (record_counter >= cfg.records_per_sensor) ? 11'd0 : record_counter;
    base        = CW'(item.sensor_index) * CW'(cfg.records_per_sensor);
    wr_addr     = base + CW'(rec_eff);
    rd_addr     = base + CW'(item.record_index);
    wr_in_range = wr_addr < DEPTH_C;
    rd_in_range = rd_addr < DEPTH_C;

    record_counter_next = record_counter;
    first_stamp_next    = first_stamp;
    last_stamp_next     = last_stamp;
    status.read_valid    = 1'b0;
    status.write_dropped = 1'b0;

    if (is_sample) begin
      record_counter_next  = rec_eff;
      status.write_dropped = !wr_in_range;
      if (item.last_sensor) begin
        if (rec_eff == 11'd0) begin
          first_stamp_next = epoch;
        end
        last_stamp_next     = epoch;
        record_counter_next = rec_eff + 11'd1;
      end
    end else if (is_read) begin
      status.read_valid = ({1'b0, item.sensor_index} < cfg.sensor_count) &&
                          ({1'b0, item.record_index} < record_counter) && rd_in_range;
    end else if (item.cmd == psl_pkg::CMD_FLUSH) begin
      record_counter_next = 11'd0;
    end

    status.record_count = record_counter_next;
    status.first_epoch  = first_stamp_next;
    status.last_epoch   = last_stamp_next;

    ram_we    = fire && is_sample && wr_in_range;
    ram_en    = ram_we || (fire && is_read && status.read_valid);
    ram_addr  = is_sample ? wr_addr[AW-1:0] : rd_addr[AW-1:0];
    ram_wdata = item.sample_ok ? item.sample_value : psl_pkg::BROKEN_MARK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      record_counter <= '0;
      first_stamp    <= '0;
      last_stamp     <= '0;
    end else if (fire) begin
      record_counter <= record_counter_next;
      first_stamp    <= first_stamp_next;
      last_stamp     <= last_stamp_next;
    end
  end

  psl_ram #(
    .WIDTH(16),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(store_q)
  );

endmodule

>>> src/periodic_sample_logger_top.sv
// Top level of the periodic sample logger.
//
// Command channel: an item (tick, sample, read, clear, wake) is taken at a
// rising edge with start high and busy low. Each item gives one result beat,
// shown on result for exactly one cycle with done high, in the cycle right
// after the item was taken. The receiver cannot stall; done is never held.
// busy is high during that result cycle, so no new item is taken until the
// result has been shown. The registered read data of the sample store RAM
// also appears in the result cycle and feeds read_data directly.
// All counters and stamps are flip-flops updated when the item is taken;
// the sample store is a single-port RAM touched at most once per sample or read.
// Configuration: wr_en/wr_index/wr_data write one register per edge, no
// wait; write only while no item is in flight.
// Reset (rst, synchronous) restores register defaults and clears counters,
// stamps and the record count. The store is not cleared; a read within the
// record count can return an entry that no sample has written.
module periodic_sample_logger_top #(
  parameter int TICK_SECONDS = 6,
  parameter int STORE_DEPTH  = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  psl_pkg::item_t    item,
  output logic              done,
  output psl_pkg::result_t  result,
  input  logic              wr_en,
  input  logic [2:0]        wr_index,
  input  logic [15:0]       wr_data
);

  psl_pkg::cfg_t          cfg;
  psl_pkg::timer_status_t tstat;
  psl_pkg::log_status_t   lstat;
  psl_pkg::result_t       res_q;
  logic                   fire;
  logic [15:0]            store_q;

  assign fire = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.measure_interval   <= psl_pkg::RST_MEASURE_INTERVAL;
      cfg.comms_interval     <= psl_pkg::RST_COMMS_INTERVAL;
      cfg.awake_seconds      <= psl_pkg::RST_AWAKE_SECONDS;
      cfg.sensor_count       <= psl_pkg::RST_SENSOR_COUNT;
      cfg.records_per_sensor <= psl_pkg::RST_RECORDS_PER_SENSOR;
    end else if (wr_en) begin
      unique case (wr_index)
        psl_pkg::REG_MEASURE_INTERVAL:   cfg.measure_interval   <= wr_data;
        psl_pkg::REG_COMMS_INTERVAL:     cfg.comms_interval     <= wr_data;
        psl_pkg::REG_AWAKE_SECONDS:      cfg.awake_seconds      <= wr_data[7:0];
        psl_pkg::REG_SENSOR_COUNT:       cfg.sensor_count       <= wr_data[3:0];
        psl_pkg::REG_RECORDS_PER_SENSOR: cfg.records_per_sensor <= wr_data[10:0];
        default: ;
      endcase
    end
  end

  psl_timers #(
    .TICK_SECONDS(TICK_SECONDS)
  ) u_timers (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .cmd   (item.cmd),
    .cfg   (cfg),
    .status(tstat)
  );

  psl_log #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_log (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item),
    .cfg    (cfg),
    .epoch  (tstat.epoch),
    .status (lstat),
    .store_q(store_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= fire;
    end
  end

  // payload captured with the item; read data joins from the RAM output, registered at the same edge
  always_ff @(posedge clk) begin
    if (fire) begin
      res_q.measure_due   <= tstat.measure_due;
      res_q.comms_due     <= tstat.comms_due;
      res_q.awake         <= tstat.awake;
      res_q.read_data     <= 16'd0;
      res_q.read_valid    <= lstat.read_valid;
      res_q.record_count  <= lstat.record_count;
      res_q.epoch_now     <= tstat.epoch;
      res_q.first_epoch   <= lstat.first_epoch;
      res_q.last_epoch    <= lstat.last_epoch;
      res_q.write_dropped <= lstat.write_dropped;
    end
  end

  assign done = busy;

  always_comb begin
    result = res_q;
    result.read_data = res_q.read_valid ? store_q : 16'd0;
  end

endmodule

>>> test/tb_top.sv
// Testbench for the periodic sample logger: predicted result beats checked field by field.
module tb_top;

  localparam int TICK  = 6;
  localparam int DEPTH = 1024;

  logic             clk;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  psl_pkg::item_t   item = '0;
  logic             done;
  psl_pkg::result_t result;
  logic             wr_en = 1'b0;
  logic [2:0]       wr_index = '0;
  logic [15:0]      wr_data = '0;

  periodic_sample_logger_top #(
    .TICK_SECONDS(TICK),
    .STORE_DEPTH (DEPTH)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .item    (item),
    .done    (done),
    .result  (result),
    .wr_en   (wr_en),
    .wr_index(wr_index),
    .wr_data (wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

  // logger state as predicted
  psl_pkg::cfg_t cfg_now;
  logic [31:0]   epoch_secs;
  logic [15:0]   meas_secs;
  logic [15:0]   comm_secs;
  logic [7:0]    awake_left;
  logic [10:0]   log_count;
  logic [31:0]   first_stamp;
  logic [31:0]   last_stamp;
  logic [15:0]   log_mem [DEPTH];
  bit            log_written [DEPTH];

  psl_pkg::item_t   pending_items[$];
  psl_pkg::result_t expected_results[$];
  int               sender_idle = 25;
  int               issued = 0;
  int               mismatches = 0;

  function automatic psl_pkg::result_t logger_predict(psl_pkg::item_t it);
    psl_pkg::result_t r;
    int               addr;
    r = '0;
    case (it.cmd)
      psl_pkg::CMD_TICK: begin
        meas_secs  = meas_secs + 16'(TICK);
        comm_secs  = comm_secs + 16'(TICK);
        epoch_secs = epoch_secs + 32'(TICK);
        awake_left = (awake_left >= 8'(TICK)) ? awake_left - 8'(TICK) : 8'd0;
        if (meas_secs >= cfg_now.measure_interval) begin
          meas_secs = '0;
          r.measure_due = 1'b1;
        end
        if (comm_secs >= cfg_now.comms_interval) begin
          comm_secs = '0;
          r.comms_due = 1'b1;
        end
      end
      psl_pkg::CMD_SAMPLE: begin
        if (log_count >= cfg_now.records_per_sensor) log_count = '0;
        addr = int'(it.sensor_index) * int'(cfg_now.records_per_sensor) + int'(log_count);
        if (addr < DEPTH) begin
          log_mem[addr]     = it.sample_ok ? it.sample_value : psl_pkg::BROKEN_MARK;
          log_written[addr] = 1'b1;
        end else begin
          r.write_dropped = 1'b1;
        end
        if (it.last_sensor) begin
          if (log_count == '0) first_stamp = epoch_secs;
          last_stamp = epoch_secs;
          log_count  = log_count + 11'd1;
        end
      end
      psl_pkg::CMD_READ: begin
        addr = int'(it.sensor_index) * int'(cfg_now.records_per_sensor) + int'(it.record_index);
        if (it.sensor_index < cfg_now.sensor_count && it.record_index < log_count &&
            addr < DEPTH) begin
          r.read_valid = 1'b1;
          r.read_data  = log_mem[addr];
        end
      end
      psl_pkg::CMD_FLUSH: log_count = '0;
      psl_pkg::CMD_WAKE:  awake_left = cfg_now.awake_seconds;
      default: ;
    endcase
    r.awake        = (awake_left != '0);
    r.record_count = log_count;
    r.epoch_now    = epoch_secs;
    r.first_epoch  = first_stamp;
    r.last_epoch   = last_stamp;
    return r;
  endfunction

  function automatic psl_pkg::item_t rand_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[33:0];
  endfunction

  function automatic psl_pkg::item_t make_item(logic [2:0] cmd, logic [2:0] s, logic [9:0] rec,
                                               logic [15:0] val, logic ok, logic last);
    psl_pkg::item_t it;
    it.cmd          = cmd;
    it.sensor_index = s;
    it.record_index = rec;
    it.sample_value = val;
    it.sample_ok    = ok;
    it.last_sensor  = last;
    return it;
  endfunction

  // queue a beat and its prediction; a read that would land on a never
  // written entry is steered out of range first, or made a tick if it cannot be
  task automatic push_item(psl_pkg::item_t it);
    int addr;
    if (it.cmd == psl_pkg::CMD_READ) begin
      addr = int'(it.sensor_index) * int'(cfg_now.records_per_sensor) + int'(it.record_index);
      if (it.sensor_index < cfg_now.sensor_count && it.record_index < log_count &&
          addr < DEPTH && !log_written[addr]) begin
        if (log_count < 11'd1024)
          it.record_index = 10'($urandom_range(1023, int'(log_count)));
        else if (cfg_now.sensor_count < 4'd8)
          it.sensor_index = 3'($urandom_range(7, int'(cfg_now.sensor_count)));
        else
          it.cmd = psl_pkg::CMD_TICK;
      end
    end
    expected_results.push_back(logger_predict(it));
    pending_items.push_back(it);
    issued++;
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
  endtask

  // only called with nothing in flight
  task automatic apply_cfg(psl_pkg::cfg_t c);
    write_reg(psl_pkg::REG_MEASURE_INTERVAL, c.measure_interval);
    write_reg(psl_pkg::REG_COMMS_INTERVAL, c.comms_interval);
    write_reg(psl_pkg::REG_AWAKE_SECONDS, 16'(c.awake_seconds));
    write_reg(psl_pkg::REG_SENSOR_COUNT, 16'(c.sensor_count));
    write_reg(psl_pkg::REG_RECORDS_PER_SENSOR, 16'(c.records_per_sensor));
    @(posedge clk);
    wr_en   <= 1'b0;
    cfg_now = c;
  endtask

  task automatic random_step();
    psl_pkg::item_t it;
    int             pick;
    int             s;
    int             sc;
    pick = $urandom_range(99);
    sc   = int'(cfg_now.sensor_count);
    it   = rand_item();
    if (pick < 35) begin
      // full measurement set, one beat per sensor
      for (s = 0; s < sc; s++) begin
        it = rand_item();
        it.cmd          = psl_pkg::CMD_SAMPLE;
        it.sensor_index = 3'(s);
        it.sample_ok    = ($urandom_range(9) != 0);
        it.last_sensor  = (s == sc - 1);
        push_item(it);
      end
    end else if (pick < 42) begin
      it.cmd = psl_pkg::CMD_SAMPLE;
      push_item(it);
    end else if (pick < 64) begin
      it.cmd = psl_pkg::CMD_READ;
      if ($urandom_range(3) != 0) begin
        it.sensor_index = 3'($urandom_range(sc - 1));
        if (log_count != '0)
          it.record_index = 10'($urandom_range(int'(log_count) - 1));
      end
      push_item(it);
    end else if (pick < 86) begin
      it.cmd = psl_pkg::CMD_TICK;
      push_item(it);
    end else if (pick < 92) begin
      it.cmd = psl_pkg::CMD_WAKE;
      push_item(it);
    end else if (pick < 95) begin
      it.cmd = psl_pkg::CMD_FLUSH;
      push_item(it);
    end else begin
      it.cmd = 3'($urandom_range(7, 5));
      push_item(it);
    end
  endtask

  // driver: one beat is offered at a time, held until taken
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) void'(pending_items.pop_front());
      if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle) begin
        start <= 1'b1;
        item  <= pending_items[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // monitor: every done beat is matched against the oldest prediction
  always @(posedge clk) begin : monitor
    psl_pkg::result_t want;
    if (!rst && done === 1'b1) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("measure_due", 32'(want.measure_due), 32'(result.measure_due));
        check_field("comms_due", 32'(want.comms_due), 32'(result.comms_due));
        check_field("awake", 32'(want.awake), 32'(result.awake));
        check_field("read_data", 32'(want.read_data), 32'(result.read_data));
        check_field("read_valid", 32'(want.read_valid), 32'(result.read_valid));
        check_field("record_count", 32'(want.record_count), 32'(result.record_count));
        check_field("epoch_now", want.epoch_now, result.epoch_now);
        check_field("first_epoch", want.first_epoch, result.first_epoch);
        check_field("last_epoch", want.last_epoch, result.last_epoch);
        check_field("write_dropped", 32'(want.write_dropped), 32'(result.write_dropped));
      end
    end
  end

  initial begin : stimulus
    psl_pkg::cfg_t plan [7];
    int            p;
    int            half;
    int            target;
    int            n;

    cfg_now     = '{psl_pkg::RST_MEASURE_INTERVAL, psl_pkg::RST_COMMS_INTERVAL,
                    psl_pkg::RST_AWAKE_SECONDS, psl_pkg::RST_SENSOR_COUNT,
                    psl_pkg::RST_RECORDS_PER_SENSOR};
    epoch_secs  = '0;
    meas_secs   = '0;
    comm_secs   = '0;
    awake_left  = '0;
    log_count   = '0;
    first_stamp = '0;
    last_stamp  = '0;
    for (n = 0; n < DEPTH; n++) log_written[n] = 1'b0;

    plan[0] = '{16'd120, 16'd3600, 8'd30, 4'd1, 11'd1024};
    plan[1] = '{16'd0, 16'd6, 8'd255, 4'd8, 11'd128};
    plan[2] = '{16'd18, 16'd65535, 8'd0, 4'd3, 11'd1};
    plan[3] = '{16'd65535, 16'd0, 8'd5, 4'd8, 11'd1024};
    plan[4] = '{16'd7, 16'd30, 8'd6, 4'd5, 11'd200};
    plan[5] = '{16'd1, 16'd1, 8'd12, 4'd2, 11'd512};
    plan[6] = '{16'd42, 16'd100, 8'd255, 4'd4, 11'd3};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero interval, underflow, broken marker, store full, reads
    apply_cfg('{16'd0, 16'd12, 8'd8, 4'd2, 11'd3});
    push_item(make_item(psl_pkg::CMD_TICK, 3'd7, 10'd1023, 16'hFFFF, 1'b1, 1'b1));
    push_item(make_item(psl_pkg::CMD_WAKE, 3'd0, 10'd0, 16'h0000, 1'b0, 1'b0));
    push_item(make_item(psl_pkg::CMD_TICK, 3'd0, 10'd0, 16'h0000, 1'b0, 1'b0));
    push_item(make_item(psl_pkg::CMD_TICK, 3'd0, 10'd0, 16'h0000, 1'b0, 1'b0));
    push_item(make_item(psl_pkg::CMD_TICK, 3'd0, 10'd0, 16'h0000, 1'b0, 1'b0));
    push_item(make_item(psl_pkg::CMD_SAMPLE, 3'd0, 10'd0, 16'hFFFF, 1'b1, 1'b0));
    push_item(make_item(psl_pkg::CMD_SAMPLE, 3'd1, 10'd0, 16'h1234, 1'b0, 1'b1));
    push_item(make_item(psl_pkg::CMD_SAMPLE, 3'd0, 10'd0, 16'h0000, 1'b1, 1'b0));
    push_item(make_item(psl_pkg::CMD_SAMPLE, 3'd1, 10'd0, 16'h8000, 1'b1, 1'b1));
    push_item(make_item(psl_pkg::CMD_SAMPLE, 3'd0, 10'd0, 16'h5555, 1'b1, 1'b0));
    push_item(make_item(psl_pkg::CMD_SAMPLE, 3'd1, 10'd0, 16'hAAAA, 1'b1, 1'b1));
    push_item(make_item(psl_pkg::CMD_SAMPLE, 3'd0, 10'd0, 16'h0001, 1'b0, 1'b0));
    push_item(make_item(psl_pkg::CMD_SAMPLE, 3'd1, 10'd0, 16'h7FFF, 1'b1, 1'b1));
    push_item(make_item(psl_pkg::CMD_READ, 3'd1, 10'd0, 16'h0000, 1'b0, 1'b0));
    push_item(make_item(psl_pkg::CMD_READ, 3'd0, 10'd0, 16'h0000, 1'b0, 1'b0));
    push_item(make_item(psl_pkg::CMD_READ, 3'd2, 10'd0, 16'h0000, 1'b0, 1'b0));
    push_item(make_item(psl_pkg::CMD_READ, 3'd0, 10'd1, 16'h0000, 1'b0, 1'b0));
    push_item(make_item(psl_pkg::CMD_READ, 3'd7, 10'd1023, 16'hFFFF, 1'b1, 1'b1));
    drain();
    apply_cfg('{16'd65535, 16'd0, 8'd255, 4'd8, 11'd1024});
    push_item(make_item(psl_pkg::CMD_WAKE, 3'd0, 10'd0, 16'h0000, 1'b0, 1'b0));
    push_item(make_item(psl_pkg::CMD_TICK, 3'd0, 10'd0, 16'h0000, 1'b0, 1'b0));
    push_item(make_item(psl_pkg::CMD_SAMPLE, 3'd5, 10'd0, 16'hBEEF, 1'b1, 1'b1));
    push_item(make_item(psl_pkg::CMD_READ, 3'd1, 10'd0, 16'h0000, 1'b0, 1'b0));
    push_item(make_item(psl_pkg::CMD_READ, 3'd0, 10'd1, 16'h0000, 1'b0, 1'b0));
    push_item(make_item(psl_pkg::CMD_FLUSH, 3'd0, 10'd0, 16'h0000, 1'b0, 1'b0));
    push_item(make_item(psl_pkg::CMD_READ, 3'd0, 10'd0, 16'h0000, 1'b0, 1'b0));
    push_item(make_item(3'd5, 3'd0, 10'd0, 16'h0000, 1'b0, 1'b0));
    push_item(make_item(3'd6, 3'd3, 10'd512, 16'h00FF, 1'b1, 1'b0));
    push_item(make_item(3'd7, 3'd7, 10'd1023, 16'hFFFF, 1'b1, 1'b1));
    drain();

    for (p = 0; p < 7; p++) begin
      sender_idle = (p < 3) ? 25 : ((p < 5) ? 76 : 0);
      apply_cfg(plan[p]);
      // hold off mid-phase until every result is back
      for (half = 0; half < 2; half++) begin
        target = issued + 125;
        while (issued < target) random_step();
        drain();
      end
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> periodic_sample_logger_top.f
src/psl_pkg.sv
src/psl_ram.sv
src/psl_timers.sv
src/psl_log.sv
src/periodic_sample_logger_top.sv
test/tb_top.sv
